[rtl/spq_pkg.sv]
`timescale 1ns / 1ps

package spq_pkg;

    localparam int DEPTH        = 16;
    localparam int PAYLOAD_BITS = 32;
    localparam int RANK_W       = 16;
    localparam int COUNT_W      = 5;
    localparam int IDX_W        = $clog2(DEPTH);
    localparam int CNT_W        = $clog2(DEPTH + 1);

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_STATUS = 2'd3;

    // command broadcast to every cell of the row
    typedef struct packed {
        logic                    ins_en;
        logic                    rem_en;
        logic                    clr_en;
        logic [RANK_W-1:0]       rank;
        logic [PAYLOAD_BITS-1:0] data;
    } cell_cmd_t;

    // what one cell shows to its neighbors
    typedef struct packed {
        logic                    valid;
        logic                    ins_here;
        logic [RANK_W-1:0]       rank;
        logic [PAYLOAD_BITS-1:0] data;
    } cell_view_t;

endpackage

[rtl/spq_cell.sv]
`timescale 1ns / 1ps

module spq_cell
(
    input  logic               clk,
    input  logic               rst_n,
    input  spq_pkg::cell_cmd_t cmd,
    input  logic               first,
    input  spq_pkg::cell_view_t left,
    input  spq_pkg::cell_view_t right,
    output spq_pkg::cell_view_t view
);

    logic                            valid_reg;
    logic                            valid_next;
    logic [spq_pkg::RANK_W-1:0]       rank_reg;
    logic [spq_pkg::RANK_W-1:0]       rank_next;
    logic [spq_pkg::PAYLOAD_BITS-1:0] data_reg;
    logic [spq_pkg::PAYLOAD_BITS-1:0] data_next;
    logic                            ins_here;

    // new entry goes behind all entries of equal or higher rank
    assign ins_here = !valid_reg || (rank_reg < cmd.rank);

    always_comb
    begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        data_next  = data_reg;
        if (cmd.clr_en)
        begin
            valid_next = 1'b0;
        end
        else if (cmd.ins_en && ins_here)
        begin
            if (!first && left.ins_here)
            begin
                // shift toward the tail
                valid_next = left.valid;
                rank_next  = left.rank;
                data_next  = left.data;
            end
            else
            begin
                valid_next = 1'b1;
                rank_next  = cmd.rank;
                data_next  = cmd.data;
            end
        end
        else if (cmd.rem_en)
        begin
            valid_next = right.valid;
            rank_next  = right.rank;
            data_next  = right.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rank_reg <= rank_next;
        data_reg <= data_next;
    end

    assign view.valid    = valid_reg;
    assign view.ins_here = ins_here;
    assign view.rank     = rank_reg;
    assign view.data     = data_reg;

endmodule

[rtl/sorted_priority_queue.sv]
`timescale 1ns / 1ps
// sorted priority queue of spq_pkg::DEPTH entries, kept in rank order in a
// row of cells (cell 0 is the front and holds the highest rank)
// input channel s_*: one request per item; s_tuser carries the operation
// (insert, remove highest, clear, status only), s_tdata the rank and payload
// output channel m_*: exactly one result per request, in request order
// the row updates at the accepting edge and the result sits in the output
// register from the next cycle on, so one request can be taken every cycle
// while m_tready is high
// insert and remove each move the whole row at once: on insert each cell
// compares the new rank with its own and takes the new entry or its left
// neighbor's entry, on remove its right neighbor's entry; clear drops the valid bits
// front and tail ranks are read from the row after the update
// when the receiver stalls, the result is held and s_tready stays low, so the
// row does not change until the result is taken
// reset empties the queue and drops any pending result; entries are not
// cleared, the per-cell valid bits are
module sorted_priority_queue
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // rank[15:0], payload[47:16]
    input  logic [1:0]  s_tuser,  // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,  // out_rank, out_payload, count, is_empty,
                                  // front_rank, tail_rank, zero fill
    output logic [0:0]  m_tuser   // status
);

    localparam int DEPTH = spq_pkg::DEPTH;

    spq_pkg::cell_view_t view [DEPTH];
    spq_pkg::cell_view_t idle_view;
    spq_pkg::cell_cmd_t  cmd;

    logic                             accept;
    logic [1:0]                       op;
    logic [spq_pkg::RANK_W-1:0]       in_rank;
    logic [31:0]                      in_payload;
    logic                             is_full;
    logic                             is_none;
    logic [spq_pkg::CNT_W-1:0]        count_reg;
    logic [spq_pkg::CNT_W-1:0]        count_next;
    logic [spq_pkg::CNT_W-1:0]        tail_pos;
    logic [spq_pkg::IDX_W-1:0]        tail_idx;
    logic                             m_valid_reg;
    logic                             m_valid_next;
    logic                             status_reg;
    logic                             status_next;
    logic [spq_pkg::RANK_W-1:0]       out_rank_reg;
    logic [spq_pkg::RANK_W-1:0]       out_rank_next;
    logic [31:0]                      out_payload_reg;
    logic [31:0]                      out_payload_next;
    logic [spq_pkg::RANK_W-1:0]       front_rank;
    logic [spq_pkg::RANK_W-1:0]       tail_rank;
    logic [spq_pkg::COUNT_W-1:0]      count_out;
    logic [DEPTH-1:0]                 valid_vec;

    assign op         = s_tuser;
    assign in_rank    = s_tdata[15:0];
    assign in_payload = s_tdata[47:16];
    assign s_tready   = !m_valid_reg || m_tready;
    assign accept     = s_tvalid && s_tready;
    assign is_full    = (count_reg == spq_pkg::CNT_W'(DEPTH));
    assign is_none    = (count_reg == '0);

    always_comb
    begin
        cmd.ins_en = accept && (op == spq_pkg::OP_INSERT) && !is_full;
        cmd.rem_en = accept && (op == spq_pkg::OP_REMOVE) && !is_none;
        cmd.clr_en = accept && (op == spq_pkg::OP_CLEAR) && !is_none;
        cmd.rank   = in_rank;
        cmd.data   = spq_pkg::PAYLOAD_BITS'(in_payload);
    end

    assign idle_view = '0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        spq_cell u_cell
        (
            .clk   (clk),
            .rst_n (rst_n),
            .cmd   (cmd),
            .first (i == 0),
            .left  ((i == 0) ? idle_view : view[(i == 0) ? 0 : i - 1]),
            .right ((i == DEPTH - 1) ? idle_view : view[(i == DEPTH - 1) ? i : i + 1]),
            .view  (view[i])
        );
        assign valid_vec[i] = view[i].valid;
    end

    always_comb
    begin
        count_next       = count_reg;
        status_next      = 1'b0;
        out_rank_next    = '0;
        out_payload_next = '0;
        unique case (op)
            spq_pkg::OP_INSERT:
            begin
                status_next = is_full;
                if (!is_full)
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            spq_pkg::OP_REMOVE:
            begin
                status_next = is_none;
                if (!is_none)
                begin
                    count_next       = count_reg - 1'b1;
                    out_rank_next    = view[0].rank;
                    out_payload_next = 32'(view[0].data);
                end
            end
            spq_pkg::OP_CLEAR:
            begin
                status_next = is_none;
                count_next  = '0;
            end
            spq_pkg::OP_STATUS:
            begin
                status_next = 1'b0;
            end
            default:
            begin
                status_next = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (accept)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg      <= status_next;
            out_rank_reg    <= out_rank_next;
            out_payload_reg <= out_payload_next;
        end
    end

    // row only changes on accept, so it matches the held result
    assign tail_pos   = count_reg - 1'b1;
    assign tail_idx   = tail_pos[spq_pkg::IDX_W-1:0];
    assign front_rank = is_none ? '0 : view[0].rank;
    assign tail_rank  = is_none ? '0 : view[tail_idx].rank;
    assign count_out  = spq_pkg::COUNT_W'(count_reg);

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {2'b00, tail_rank, front_rank, is_none, count_out,
                       out_payload_reg, out_rank_reg};

`ifndef SYNTH
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= spq_pkg::CNT_W'(DEPTH))
        else $error("entry count beyond depth");

    a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == 32'(count_reg))
        else $error("cell valid bits disagree with entry count");

    a_front_valid: assert property (@(posedge clk) disable iff (!rst_n)
        view[0].valid == !is_none)
        else $error("front cell valid bit disagrees with count");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> m_tvalid)
        else $error("accepted request produced no result");

    a_sorted_front: assert property (@(posedge clk) disable iff (!rst_n)
        view[1].valid |-> (view[0].rank >= view[1].rank))
        else $error("front entries out of rank order");
`endif

endmodule
